[rtl/core/lmat_pkg.sv]
package lmat_pkg;

  // table size and derived address width
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // field widths
  localparam int unsigned POS_W     = 24;
  localparam int unsigned RANGE_W   = 24;
  localparam int unsigned BEARING_W = 16;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SEEN_W    = 16;
  localparam int unsigned RADIUS_W  = 16;
  localparam int unsigned LIFE_W    = 8;
  localparam int unsigned R2_W      = 2 * RADIUS_W;
  localparam int unsigned SQ_W      = 2 * POS_W;
  localparam int unsigned SUM_W     = SQ_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIFE_RESET   = CFG_IDX_W'(1);

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1000);
  localparam logic [LIFE_W-1:0]   LIFE_RST   = LIFE_W'(40);

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_MATCHED = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_ADDED   = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_FULL    = STATUS_W'(2);

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  // per-entry attributes kept beside the position
  typedef struct packed {
    logic [LIFE_W-1:0]           life;
    logic [SEEN_W-1:0]           seen;
    logic [RANGE_W-1:0]          range;
    logic signed [BEARING_W-1:0] bearing;
  } attr_t;

  // token that walks the compare chain
  typedef struct packed {
    logic              valid;
    logic [AW-1:0]     idx;
    logic [SEEN_W-1:0] seen;
  } tok_t;

  // magnitude of the difference of two signed positions
  function automatic logic [POS_W-1:0] absdiff(input logic signed [POS_W-1:0] a,
                                               input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[POS_W] ? POS_W'(-d) : d[POS_W-1:0];
  endfunction

endpackage

[rtl/core/lmat_ram.sv]
module lmat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/lmat_dist_chain.sv]
module lmat_dist_chain
  import lmat_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    flush_i,
  input  tok_t                    tok_i,
  input  logic signed [POS_W-1:0] ent_x_i,
  input  logic signed [POS_W-1:0] ent_y_i,
  input  logic signed [POS_W-1:0] qx_i,
  input  logic signed [POS_W-1:0] qy_i,
  input  logic [R2_W-1:0]         r2_i,
  output tok_t                    tok_o,
  output logic                    hit_o,
  output logic                    busy_o
);

  tok_t s1_tok_q, s2_tok_q, s3_tok_q;
  logic [POS_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]  sqx_q, sqy_q;
  logic             hit_q;
  logic [SQ_W-1:0]  sqx_d, sqy_d;
  logic [SUM_W-1:0] dist2;
  logic             hit_d;

  // squares and squared distance compare
  always_comb begin
    sqx_d = SQ_W'(dx_q) * SQ_W'(dx_q);
    sqy_d = SQ_W'(dy_q) * SQ_W'(dy_q);
    dist2 = SUM_W'(sqx_q) + SUM_W'(sqy_q);
    hit_d = dist2 < SUM_W'(r2_i);
  end

  // tokens hop one cell per cycle, a flush drops every valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tok_q <= '0;
      s2_tok_q <= '0;
      s3_tok_q <= '0;
    end else if (flush_i) begin
      s1_tok_q.valid <= 1'b0;
      s2_tok_q.valid <= 1'b0;
      s3_tok_q.valid <= 1'b0;
    end else begin
      s1_tok_q <= tok_i;
      s2_tok_q <= s1_tok_q;
      s3_tok_q <= s2_tok_q;
    end
  end

  // distance datapath of each cell
  always_ff @(posedge clk_i) begin
    dx_q  <= absdiff(qx_i, ent_x_i);
    dy_q  <= absdiff(qy_i, ent_y_i);
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
    hit_q <= hit_d;
  end

  assign tok_o  = s3_tok_q;
  assign hit_o  = s3_tok_q.valid & hit_q;
  assign busy_o = tok_i.valid | s1_tok_q.valid | s2_tok_q.valid | s3_tok_q.valid;

endmodule

[rtl/core/landmark_association_table_unit.sv]
// channel | dir | handshake                | payload
// --------+-----+--------------------------+---------------------------------------------
// in      | in  | in_valid_i / in_ready_o  | pos_x_i, pos_y_i, obs_range_i, obs_bearing_i
// out     | out | out_valid_o / out_ready_i| landmark_index_o, status_o, times_seen_o
// cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one request at a time; a scan reads one stored entry per cycle from the position RAM
// the result is loaded when the scan ends: a hit ends it early, once the hit entry has left
// the RAM read stage and the three-cell compare chain; else it ends when every held entry
// has passed through them, and with an empty table the scan reads nothing
// reset empties the table (entry count zero), no clearing pass is needed
// a new request is taken while the previous result still waits in the output register
// a stalled output holds the table update until the result register is free
module landmark_association_table_unit
  import lmat_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [POS_W-1:0]     pos_x_i,
  input  logic signed [POS_W-1:0]     pos_y_i,
  input  logic [RANGE_W-1:0]          obs_range_i,
  input  logic signed [BEARING_W-1:0] obs_bearing_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [INDEX_W-1:0]          landmark_index_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic [SEEN_W-1:0]           times_seen_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  logic [RADIUS_W-1:0] radius_q;
  logic [LIFE_W-1:0]   life_q;

  logic signed [POS_W-1:0]     qx_q, qy_q;
  logic [RANGE_W-1:0]          rng_q;
  logic signed [BEARING_W-1:0] brg_q;
  logic [R2_W-1:0]             r2_q;

  logic [AW-1:0] count_q, count_d;
  logic [AW-1:0] issue_q, issue_d;
  logic          rd_valid_q, rd_valid_d;
  logic [AW-1:0] rd_idx_q;

  logic              found_q, found_d;
  logic [AW-1:0]     fidx_q, fidx_d;
  logic [SEEN_W-1:0] fseen_q, fseen_d;

  logic                 out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]   out_idx_q, out_idx_d;
  logic [STATUS_W-1:0]  out_stat_q, out_stat_d;
  logic [SEEN_W-1:0]    out_seen_q, out_seen_d;

  logic [2*POS_W-1:0] xy_rdata, xy_wdata;
  attr_t              attr_rdata, attr_wdata;
  logic               xy_we, attr_we;
  logic [AW-1:0]      waddr;

  tok_t chain_in, chain_out;
  logic chain_hit, chain_busy, flush;
  logic issuing, fin_go, can_add;
  logic [SEEN_W-1:0] seen_inc;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      life_q   <= LIFE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MATCH_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        REG_LIFE_RESET:   life_q   <= cfg_data_i[LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  // position and attribute stores
  lmat_ram #(.WIDTH(2 * POS_W), .DEPTH(DEPTH)) u_xy_ram (
    .clk_i   (clk_i),
    .we_i    (xy_we),
    .waddr_i (waddr),
    .wdata_i (xy_wdata),
    .raddr_i (issue_q),
    .rdata_o (xy_rdata)
  );

  lmat_ram #(.WIDTH($bits(attr_t)), .DEPTH(DEPTH)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .waddr_i (waddr),
    .wdata_i (attr_wdata),
    .raddr_i (issue_q),
    .rdata_o (attr_rdata)
  );

  // compare chain fed by the registered RAM read
  assign chain_in.valid = rd_valid_q;
  assign chain_in.idx   = rd_idx_q;
  assign chain_in.seen  = attr_rdata.seen;

  lmat_dist_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (flush),
    .tok_i   (chain_in),
    .ent_x_i (xy_rdata[2*POS_W-1:POS_W]),
    .ent_y_i (xy_rdata[POS_W-1:0]),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .r2_i    (r2_q),
    .tok_o   (chain_out),
    .hit_o   (chain_hit),
    .busy_o  (chain_busy)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign issuing    = (state_q == ST_SCAN) && (issue_q != count_q) && !chain_hit;
  assign fin_go     = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign can_add    = (count_q != AW'(DEPTH - 1));
  assign seen_inc   = (fseen_q == SEEN_MAX) ? SEEN_MAX : fseen_q + SEEN_W'(1);

  // table update on the finishing cycle
  always_comb begin
    xy_we              = 1'b0;
    attr_we            = 1'b0;
    waddr              = fidx_q;
    xy_wdata           = {qx_q, qy_q};
    attr_wdata.life    = life_q;
    attr_wdata.seen    = seen_inc;
    attr_wdata.range   = rng_q;
    attr_wdata.bearing = brg_q;
    if (fin_go) begin
      if (found_q) begin
        attr_we = 1'b1;
      end else if (can_add) begin
        xy_we           = 1'b1;
        attr_we         = 1'b1;
        waddr           = count_q;
        attr_wdata.seen = SEEN_W'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    rd_valid_d  = 1'b0;
    found_d     = found_q;
    fidx_d      = fidx_q;
    fseen_d     = fseen_q;
    flush       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_stat_d  = out_stat_q;
    out_seen_d  = out_seen_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
          issue_d = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          issue_d    = issue_q + AW'(1);
          rd_valid_d = 1'b1;
        end
        if (chain_hit) begin
          found_d = 1'b1;
          fidx_d  = chain_out.idx;
          fseen_d = chain_out.seen;
          flush   = 1'b1;
          state_d = ST_FIN;
        end else if ((issue_q == count_q) && !chain_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (found_q) begin
            out_idx_d  = INDEX_W'(fidx_q);
            out_stat_d = STAT_MATCHED;
            out_seen_d = seen_inc;
          end else if (can_add) begin
            out_idx_d  = INDEX_W'(count_q);
            out_stat_d = STAT_ADDED;
            out_seen_d = SEEN_W'(1);
            count_d    = count_q + AW'(1);
          end else begin
            out_idx_d  = '0;
            out_stat_d = STAT_FULL;
            out_seen_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      rd_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      rd_valid_q  <= rd_valid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture and payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      qx_q  <= pos_x_i;
      qy_q  <= pos_y_i;
      rng_q <= obs_range_i;
      brg_q <= obs_bearing_i;
      r2_q  <= R2_W'(radius_q) * R2_W'(radius_q);
    end
    rd_idx_q   <= issue_q;
    fidx_q     <= fidx_d;
    fseen_q    <= fseen_d;
    out_idx_q  <= out_idx_d;
    out_stat_q <= out_stat_d;
    out_seen_q <= out_seen_d;
  end

  assign out_valid_o      = out_valid_q;
  assign landmark_index_o = out_idx_q;
  assign status_o         = out_stat_q;
  assign times_seen_o     = out_seen_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= AW'(DEPTH - 1))
    else $error("entry count beyond table capacity");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q <= count_q)
    else $error("scan read past the held entries");

  a_chain_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_busy |-> (state_q == ST_SCAN))
    else $error("compare chain active outside a scan");

  a_fin_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished request did not reach the result register");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_FULL)) |-> (landmark_index_o == '0)
      && (times_seen_o == '0))
    else $error("full result carries a nonzero index or count");

endmodule
